// File: sv/sb2dec_pkg.sv
// Package for the signed binary to decimal ASCII converter.
// Holds character constants, microcode types and the microcode program.
// No dependencies.
`default_nettype none

package sb2dec_pkg;

  localparam int IN_WIDTH = 64;
  localparam int DEF_NUMBER_WIDTH = 64;

  typedef logic [7:0] char_t;

  localparam char_t CHAR_ZERO  = 8'd48;
  localparam char_t CHAR_MINUS = 8'd45;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_START,
    C_MORE_BITS,
    C_LEAD_ZERO,
    C_NEVER,
    C_MORE_DIGITS
  } ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    step_t  target;
    step_t  next;
  } uword_t;

  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_DABBLE = 3'd1;
  localparam step_t S_SKIP   = 3'd2;
  localparam step_t S_SIGN   = 3'd3;
  localparam step_t S_EMIT   = 3'd4;

  // Each step jumps to target when its condition holds, else goes to next.
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    unique case (pc)
      S_IDLE:   w = '{op: OP_IDLE,   cond: C_START,       target: S_DABBLE, next: S_IDLE};
      S_DABBLE: w = '{op: OP_DABBLE, cond: C_MORE_BITS,   target: S_DABBLE, next: S_SKIP};
      S_SKIP:   w = '{op: OP_SKIP,   cond: C_LEAD_ZERO,   target: S_SKIP,   next: S_SIGN};
      S_SIGN:   w = '{op: OP_SIGN,   cond: C_NEVER,       target: S_SIGN,   next: S_EMIT};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_MORE_DIGITS, target: S_EMIT,   next: S_IDLE};
      default:  w = '{op: OP_IDLE,   cond: C_NEVER,       target: S_IDLE,   next: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/signed_binary_to_decimal_ascii_top.sv
// Signed binary to decimal ASCII converter, top level.
// Microcoded sequencer over a shift-and-add-3 datapath; uses sb2dec_pkg.
`default_nettype none

// A number is taken when start is high and busy is low. Its magnitude is
// converted by shift-and-add-3, one bit per cycle, then leading zero digits
// are dropped one per cycle, the sign is handled in its own step, and the
// characters follow on consecutive cycles, each on the out_ ports for one
// cycle with out_strobe high; out_last_char marks the final one. Every digit
// slot is either skipped or emitted; there are 19 digit slots at width 64.
// The last character is on the outputs in the first cycle with busy low, so
// the next number can be taken then. The receiver cannot stall the output.
module signed_binary_to_decimal_ascii_top #(
  parameter int NUMBER_WIDTH = sb2dec_pkg::DEF_NUMBER_WIDTH
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [sb2dec_pkg::IN_WIDTH-1:0] in_number,
  output logic                                        out_strobe,
  output sb2dec_pkg::char_t                           out_char_code,
  output logic                                        out_last_char
);
  import sb2dec_pkg::*;

  // Decimal digits of 2^(NUMBER_WIDTH-1), the largest magnitude.
  localparam int NDIG  = ((NUMBER_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int BC_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int DC_W  = $clog2(NDIG + 1);

  step_t                   pc_r, pc_nxt;
  logic [NUMBER_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic                    neg_r, neg_nxt;
  logic [BC_W-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [DC_W-1:0]         dig_cnt_r, dig_cnt_nxt;
  logic                    strobe_r, strobe_nxt;
  char_t                   char_r, char_nxt;
  logic                    last_r, last_nxt;

  uword_t                  uw;
  logic                    cond_ok;
  logic                    accept;
  logic [NUMBER_WIDTH-1:0] raw;
  logic [BCD_W-1:0]        bcd_adj;
  logic [3:0]              top_dig;
  logic                    lead_zero;

  assign uw        = ucode_rom(pc_r);
  assign busy      = (pc_r != S_IDLE);
  assign accept    = start && !busy;
  assign raw       = in_number[NUMBER_WIDTH-1:0];
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign lead_zero = (top_dig == 4'd0) && (dig_cnt_r != DC_W'(1));

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_START:       cond_ok = start;
      C_MORE_BITS:   cond_ok = (bit_cnt_r != BC_W'(1));
      C_LEAD_ZERO:   cond_ok = lead_zero;
      C_NEVER:       cond_ok = 1'b0;
      C_MORE_DIGITS: cond_ok = (dig_cnt_r != DC_W'(1));
      default:       cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt      = cond_ok ? uw.target : uw.next;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    neg_nxt     = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    strobe_nxt  = 1'b0;
    char_nxt    = char_r;
    last_nxt    = last_r;
    unique case (uw.op)
      OP_IDLE: begin
        if (accept) begin
          neg_nxt     = raw[NUMBER_WIDTH-1];
          bin_nxt     = raw[NUMBER_WIDTH-1] ? (~raw + NUMBER_WIDTH'(1)) : raw;
          bcd_nxt     = '0;
          bit_cnt_nxt = BC_W'(NUMBER_WIDTH);
          dig_cnt_nxt = DC_W'(NDIG);
        end
      end
      OP_DABBLE: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[NUMBER_WIDTH-1]};
        bin_nxt     = {bin_r[NUMBER_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BC_W'(1);
      end
      OP_SKIP: begin
        if (lead_zero) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - DC_W'(1);
        end
      end
      OP_SIGN: begin
        if (neg_r) begin
          strobe_nxt = 1'b1;
          char_nxt   = CHAR_MINUS;
          last_nxt   = 1'b0;
        end
      end
      OP_EMIT: begin
        strobe_nxt  = 1'b1;
        char_nxt    = CHAR_ZERO + {4'd0, top_dig};
        last_nxt    = (dig_cnt_r == DC_W'(1));
        bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
        dig_cnt_nxt = dig_cnt_r - DC_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      strobe_r <= strobe_nxt;
    end
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    neg_r     <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  // The final beat of a number coincides with the sequencer returning to idle.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_char |-> !busy)
    else $error("last character seen while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted number did not raise busy");

  // Characters of one number come out on consecutive cycles.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_char |=> out_strobe)
    else $error("gap inside a character run");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_char_code == CHAR_MINUS) ||
                   (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 8'd9))
    else $error("character code out of range");

endmodule

`default_nettype wire
